// ===== hdl/lps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Shared widths and the line descriptor passed from the front end to the
// walker.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int COORD_W = 6;
  localparam int IDX_W   = 12;
  localparam int ERR_W   = 8;
  localparam int CNT_W   = 6;

  localparam logic [CNT_W-1:0] LAST_COUNT = {CNT_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] ady;
    logic               sx_neg;
    logic               sy_neg;
    logic [ERR_W-1:0]   err;
  } line_desc_t;

endpackage

// ===== hdl/line_pixel_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper
// Walks a line segment with the integer Bresenham rule and gives one
// transaction per covered pixel with its column, row and linear index.
// ----------------------------------------------------------------------------
// A line of N pixels (N is the larger of the column and row distances plus
// one, 1 to 64) is loaded from the two-entry descriptor queue and then
// walked by the walker, which updates the error term once per cycle. Lines
// are accepted into that queue while the walker is
// busy. The output register holds each pixel until it is popped, and the
// walker stalls while a pixel waits there unpopped. pixel_index is x plus y
// times SCREEN_WIDTH, truncated to 12 bits; coordinates are not clipped.
module line_pixel_stepper #(
  parameter int SCREEN_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [lps_pkg::COORD_W-1:0]  in_start_x,
  input  logic [lps_pkg::COORD_W-1:0]  in_start_y,
  input  logic [lps_pkg::COORD_W-1:0]  in_end_x,
  input  logic [lps_pkg::COORD_W-1:0]  in_end_y,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [lps_pkg::COORD_W-1:0]  out_pixel_x,
  output logic [lps_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [lps_pkg::IDX_W-1:0]    out_pixel_index,
  output logic                         out_last_pixel
);

  lps_pkg::line_desc_t front_desc;
  lps_pkg::line_desc_t q_data;
  logic                q_empty;
  logic                q_pop;

  lps_front u_front (
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .desc    (front_desc)
  );

  lps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_desc),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  lps_walker #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_index (out_pixel_index),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ===== hdl/lps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper front end
// Turns the two endpoints of a line into the walk descriptor: distances,
// step directions and the starting error term.
// ----------------------------------------------------------------------------
module lps_front (
  input  logic [lps_pkg::COORD_W-1:0] start_x,
  input  logic [lps_pkg::COORD_W-1:0] start_y,
  input  logic [lps_pkg::COORD_W-1:0] end_x,
  input  logic [lps_pkg::COORD_W-1:0] end_y,
  output lps_pkg::line_desc_t         desc
);

  logic [lps_pkg::COORD_W-1:0] dx;
  logic [lps_pkg::COORD_W-1:0] ady;

  always_comb begin
    dx  = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
    ady = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
    desc.x      = start_x;
    desc.y      = start_y;
    desc.xe     = end_x;
    desc.ye     = end_y;
    desc.dx     = dx;
    desc.ady    = ady;
    desc.sx_neg = !(start_x < end_x);
    desc.sy_neg = !(start_y < end_y);
    desc.err    = {2'b00, dx} - {2'b00, ady};
  end

endmodule

// ===== hdl/lps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper descriptor queue
// Two-entry queue that decouples line acceptance from the pixel walk.
// ----------------------------------------------------------------------------
module lps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lps_pkg::line_desc_t wr_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output lps_pkg::line_desc_t rd_data
);

  lps_pkg::line_desc_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("descriptor queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("descriptor queue pointers disagree with count");
`endif

endmodule

// ===== hdl/lps_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper walker
// Steps one pixel per cycle, unless a pixel waits untaken, with the Bresenham
// error rule and holds each pixel in an output register until it is taken.
// ----------------------------------------------------------------------------
module lps_walker #(
  parameter int SCREEN_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  lps_pkg::line_desc_t          q_data,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [lps_pkg::COORD_W-1:0]  out_pixel_x,
  output logic [lps_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [lps_pkg::IDX_W-1:0]    out_pixel_index,
  output logic                         out_last_pixel
);

  lps_pkg::line_desc_t          cur_r;
  logic                         busy_r;
  logic [lps_pkg::CNT_W-1:0]    cnt_r;
  logic                         out_valid_r;
  logic [lps_pkg::COORD_W-1:0]  out_x_r;
  logic [lps_pkg::COORD_W-1:0]  out_y_r;
  logic [lps_pkg::IDX_W-1:0]    out_idx_r;
  logic                         out_last_r;

  logic signed [lps_pkg::ERR_W:0] e2;
  logic signed [lps_pkg::ERR_W:0] neg_ady;
  logic signed [lps_pkg::ERR_W:0] pos_dx;
  logic                           move_x;
  logic                           move_y;
  logic                           last_c;
  logic                           advance;
  logic [lps_pkg::COORD_W-1:0]    x_nxt;
  logic [lps_pkg::COORD_W-1:0]    y_nxt;
  logic [lps_pkg::ERR_W-1:0]      err_nxt;
  logic [lps_pkg::IDX_W-1:0]      idx_c;

  always_comb begin
    e2      = {cur_r.err[lps_pkg::ERR_W-1], cur_r.err} <<< 1;
    neg_ady = -$signed({3'b000, cur_r.ady});
    pos_dx  = $signed({3'b000, cur_r.dx});
    move_x  = (e2 >= neg_ady);
    move_y  = (e2 <= pos_dx);
    last_c  = ((cur_r.x == cur_r.xe) && (cur_r.y == cur_r.ye)) ||
              (move_x && (cur_r.x == cur_r.xe)) ||
              (move_y && (cur_r.y == cur_r.ye)) ||
              (cnt_r == lps_pkg::LAST_COUNT);
    x_nxt   = cur_r.x;
    y_nxt   = cur_r.y;
    err_nxt = cur_r.err;
    if (move_x) begin
      x_nxt   = cur_r.sx_neg ? (cur_r.x - 1'b1) : (cur_r.x + 1'b1);
      err_nxt = err_nxt - {2'b00, cur_r.ady};
    end
    if (move_y) begin
      y_nxt   = cur_r.sy_neg ? (cur_r.y - 1'b1) : (cur_r.y + 1'b1);
      err_nxt = err_nxt + {2'b00, cur_r.dx};
    end
    idx_c = lps_pkg::IDX_W'({6'b0, cur_r.x}) +
            lps_pkg::IDX_W'(cur_r.y * SCREEN_WIDTH);
  end

  assign advance = busy_r && (!out_valid_r || out_pop);
  assign q_pop   = !busy_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (advance) begin
        busy_r <= !last_c;
        cnt_r  <= cnt_r + 1'b1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end else if (advance) begin
      cur_r.x   <= x_nxt;
      cur_r.y   <= y_nxt;
      cur_r.err <= err_nxt;
    end
    if (advance) begin
      out_x_r    <= cur_r.x;
      out_y_r    <= cur_r.y;
      out_idx_r  <= idx_c;
      out_last_r <= last_c;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_index = out_idx_r;
  assign out_last_pixel  = out_last_r;

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !busy_r)
    else $error("new line loaded while a walk is in progress");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last_c) |=> (!busy_r && out_valid_r && out_last_r))
    else $error("walk did not end on its last pixel");

  a_step_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !last_c) |=> (busy_r && !out_last_r))
    else $error("walk stopped before its last pixel");

  a_nonfinal_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !last_c) |-> (move_x || move_y))
    else $error("walk step moved neither coordinate");
`endif

endmodule
